@@ rtl/llf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llf_pkg: shared types and constants of the logical line filter
// Word layouts of both channels, configuration bundle and register map.
// ----------------------------------------------------------------------------
package llf_pkg;

    localparam int          QueueDepth     = 4;
    localparam int          AddrWidth      = 4;
    localparam logic [7:0]  TerminatorRst  = 8'd10;
    localparam logic [7:0]  QuoteRst       = 8'd92;
    localparam logic [7:0]  CommentRst     = 8'd35;

    typedef enum logic [1:0] {
        REG_TERMINATOR = 2'd0,
        REG_QUOTE      = 2'd1,
        REG_COMMENT    = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_byte;
        logic        line_end;
        logic [31:0] first_line;
        logic [31:0] last_line;
    } out_word_t;

    typedef struct packed {
        logic [7:0] terminator_char;
        logic [7:0] quote_char;
        logic [7:0] comment_char;
    } cfg_t;

    // results produced by one input word, at most two
    typedef struct packed {
        logic [1:0] count;
        out_word_t  res0;
        out_word_t  res1;
    } step_t;

endpackage

@@ rtl/llf_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llf_core: per-word line state machine
// Holds line start, comment and held-quote flags and the line counters,
// and works out the zero, one or two results caused by each accepted word.
// ----------------------------------------------------------------------------
module llf_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  llf_pkg::in_word_t item,
    input  llf_pkg::cfg_t     cfg,
    output llf_pkg::step_t    step
);

    logic        at_start_reg, at_start_next;
    logic        in_comment_reg, in_comment_next;
    logic        quote_held_reg, quote_held_next;
    logic [31:0] first_reg, first_next;
    logic [31:0] last_reg, last_next;

    logic              is_term;
    logic              is_quote;
    logic              is_comment;
    llf_pkg::out_word_t r0;
    llf_pkg::out_word_t r1;
    logic [1:0]        n;

    assign is_term    = (item.in_byte == cfg.terminator_char);
    assign is_quote   = (item.in_byte == cfg.quote_char);
    assign is_comment = (item.in_byte == cfg.comment_char);

    always_comb
    begin
        at_start_next   = at_start_reg;
        in_comment_next = in_comment_reg;
        quote_held_next = quote_held_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        n               = 2'd0;
        r0.out_byte     = item.in_byte;
        r0.has_byte     = 1'b1;
        r0.line_end     = 1'b0;
        r1.out_byte     = item.in_byte;
        r1.has_byte     = 1'b1;
        r1.line_end     = 1'b0;

        if (item.end_of_input)
        begin
            if (!at_start_reg && !in_comment_reg)
            begin
                if (quote_held_reg)
                begin
                    r0.out_byte = cfg.quote_char;
                    r1.out_byte = 8'd0;
                    r1.has_byte = 1'b0;
                    r1.line_end = 1'b1;
                    n           = 2'd2;
                end
                else
                begin
                    r0.out_byte = 8'd0;
                    r0.has_byte = 1'b0;
                    r0.line_end = 1'b1;
                    n           = 2'd1;
                end
            end
            at_start_next   = 1'b1;
            in_comment_next = 1'b0;
            quote_held_next = 1'b0;
        end
        else if (at_start_reg)
        begin
            last_next  = last_reg + 32'd1;
            first_next = last_reg + 32'd1;
            if (!is_term)
            begin
                at_start_next = 1'b0;
                if (is_comment)
                    in_comment_next = 1'b1;
                else
                    n = 2'd1;
            end
        end
        else if (in_comment_reg)
        begin
            if (is_term)
            begin
                at_start_next   = 1'b1;
                in_comment_next = 1'b0;
                quote_held_next = 1'b0;
            end
        end
        else if (is_term)
        begin
            if (quote_held_reg)
            begin
                // quoted terminator joins the next physical line
                quote_held_next = 1'b0;
                last_next       = last_reg + 32'd1;
            end
            else
            begin
                r0.line_end     = 1'b1;
                n               = 2'd1;
                at_start_next   = 1'b1;
                quote_held_next = 1'b0;
            end
        end
        else
        begin
            quote_held_next = is_quote;
            if (quote_held_reg)
            begin
                r0.out_byte = cfg.quote_char;
                n           = is_quote ? 2'd1 : 2'd2;
            end
            else
            begin
                n = is_quote ? 2'd0 : 2'd1;
            end
        end

        // results always carry the counts as they stand after this word
        r0.first_line = first_next;
        r0.last_line  = last_next;
        r1.first_line = first_next;
        r1.last_line  = last_next;
    end

    assign step.count = accept ? n : 2'd0;
    assign step.res0  = r0;
    assign step.res1  = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg   <= 1'b1;
            in_comment_reg <= 1'b0;
            quote_held_reg <= 1'b0;
            first_reg      <= 32'd0;
            last_reg       <= 32'd0;
        end
        else if (accept)
        begin
            at_start_reg   <= at_start_next;
            in_comment_reg <= in_comment_next;
            quote_held_reg <= quote_held_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
        end
    end

endmodule

@@ rtl/llf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llf_queue: result queue
// Takes up to two result words a cycle and hands one a cycle to the output while it is ready.
// ----------------------------------------------------------------------------
module llf_queue
#(
    parameter int DEPTH = llf_pkg::QueueDepth
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  llf_pkg::step_t     step,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output llf_pkg::out_word_t out_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    llf_pkg::out_word_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;
    logic [PW-1:0] wr_ptr_plus1;

    assign pop          = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + PW'(1);
    assign wr_ptr_next  = wr_ptr_reg + PW'(step.count);
    assign rd_ptr_next  = rd_ptr_reg + PW'(pop);
    assign count_next   = count_reg + CW'(step.count) - CW'(pop);

    // room for a word's worst case of two results
    assign room      = (count_reg <= CW'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (step.count != 2'd0)
            mem[wr_ptr_reg] <= step.res0;
        if (step.count == 2'd2)
            mem[wr_ptr_plus1] <= step.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/logical_line_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// logical_line_filter: byte stream to logical lines
// Drops blank and comment lines, joins quoted line ends, tags line numbers.
//
//   port group   direction  handshake        payload
//   in_*         in         valid / ready    in_byte, end_of_input
//   out_*        out        valid / ready    out_byte, has_byte, line_end, lines
//   apb          in         psel / penable   terminator, quote, comment bytes
//
// One input word is taken per cycle while the result queue has room for two.
// A word's results are written at the edge that accepts it; the first can leave
// at the next edge.
// A word that yields two results hands them out one after the other; the queue depth
// (DEPTH, a power of two, at least 2) sets how much output stall is absorbed.
// Reset clears the line state, counters and queue and loads default bytes.
// ----------------------------------------------------------------------------
module logical_line_filter
#(
    parameter int DEPTH = llf_pkg::QueueDepth
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  llf_pkg::in_word_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output llf_pkg::out_word_t                out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [llf_pkg::AddrWidth-1:0]     paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    llf_pkg::cfg_t  cfg_reg;
    llf_pkg::step_t step;
    logic           room;
    logic           accept;
    logic           wr_en;
    logic [1:0]     reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.terminator_char <= llf_pkg::TerminatorRst;
            cfg_reg.quote_char      <= llf_pkg::QuoteRst;
            cfg_reg.comment_char    <= llf_pkg::CommentRst;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                llf_pkg::REG_TERMINATOR: cfg_reg.terminator_char <= pwdata[7:0];
                llf_pkg::REG_QUOTE:      cfg_reg.quote_char      <= pwdata[7:0];
                llf_pkg::REG_COMMENT:    cfg_reg.comment_char    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            llf_pkg::REG_TERMINATOR: prdata = {24'd0, cfg_reg.terminator_char};
            llf_pkg::REG_QUOTE:      prdata = {24'd0, cfg_reg.quote_char};
            llf_pkg::REG_COMMENT:    prdata = {24'd0, cfg_reg.comment_char};
            default:                 prdata = 32'd0;
        endcase
    end

    assign in_ready = room;
    assign accept   = in_valid && in_ready;

    llf_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .cfg    (cfg_reg),
        .step   (step)
    );

    llf_queue #(.DEPTH(DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ verif/tb_logical_line_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_logical_line_filter: self-checking bench for the logical line filter
// Drives byte streams on the input channel and tracks line state in the bench
// to predict every output word. Checks each word field by field in arrival
// order. Covers the default and extreme settings of the three register bytes,
// equal bytes, and end of input in every line state. Both sides idle at random
// and there is one long receiver hold.
// ----------------------------------------------------------------------------
module tb_logical_line_filter;

    localparam int          CycleLimit    = 600000;
    localparam int          SettleCycles  = 8;
    localparam int          EndMark       = -1;
    localparam int          UnusedReg     = 3;
    localparam int          LineTarget    = 310;
    localparam int          MaxReports    = 40;
    localparam int          AddrWidth     = llf_pkg::AddrWidth;
    localparam logic [7:0]  TerminatorRst = llf_pkg::TerminatorRst;
    localparam logic [7:0]  QuoteRst      = llf_pkg::QuoteRst;
    localparam logic [7:0]  CommentRst    = llf_pkg::CommentRst;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    llf_pkg::in_word_t    in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    llf_pkg::out_word_t   out_data;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [AddrWidth-1:0] paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // bench copy of the register bytes and the line state
    llf_pkg::cfg_t rules;
    logic          at_start;
    logic          in_cmt;
    logic          quote_pend;
    logic [31:0]   line_first;
    logic [31:0]   line_last;

    llf_pkg::out_word_t line_bytes_due[$];
    int                 script[$];

    int          tx_gap_max = 0;
    int          rx_stall_max = 0;
    int          rx_hold_len = 0;
    int          errors = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          lines_closed = 0;
    int          settings = 0;
    int          cycle_count = 0;

    logical_line_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("%0t: timeout after %0d cycles, %0d words still due",
                     $time, cycle_count, line_bytes_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // line state tracking
    // ------------------------------------------------------------------
    function automatic void expect_word(logic [7:0] b, logic has, logic fin);
        llf_pkg::out_word_t w;
        w.out_byte   = has ? b : 8'd0;
        w.has_byte   = has;
        w.line_end   = fin;
        w.first_line = line_first;
        w.last_line  = line_last;
        line_bytes_due.push_back(w);
    endfunction

    function automatic void rewind_line();
        at_start   = 1'b1;
        in_cmt     = 1'b0;
        quote_pend = 1'b0;
    endfunction

    function automatic void track_line(llf_pkg::in_word_t w);
        logic [7:0] b;
        b = w.in_byte;
        if (w.end_of_input)
        begin
            if (!at_start && !in_cmt)
            begin
                if (quote_pend)
                    expect_word(rules.quote_char, 1'b1, 1'b0);
                expect_word(8'd0, 1'b0, 1'b1);
            end
            rewind_line();
            return;
        end
        if (at_start)
        begin
            line_last  = line_last + 32'd1;
            line_first = line_last;
            if (b == rules.terminator_char)
                return;
            at_start = 1'b0;
            if (b == rules.comment_char)
            begin
                in_cmt = 1'b1;
                return;
            end
            expect_word(b, 1'b1, 1'b0);
            return;
        end
        if (in_cmt)
        begin
            if (b == rules.terminator_char)
                rewind_line();
            return;
        end
        if (b == rules.terminator_char)
        begin
            // quoted line end: both bytes vanish and the next physical line joins
            if (quote_pend)
            begin
                quote_pend = 1'b0;
                line_last  = line_last + 32'd1;
                return;
            end
            expect_word(b, 1'b1, 1'b1);
            rewind_line();
            return;
        end
        if (quote_pend)
        begin
            expect_word(rules.quote_char, 1'b1, 1'b0);
            quote_pend = 1'b0;
        end
        if (b == rules.quote_char)
            quote_pend = 1'b1;
        else
            expect_word(b, 1'b1, 1'b0);
    endfunction

    // ------------------------------------------------------------------
    // output side: per-word stall draw, long hold on request
    // ------------------------------------------------------------------
    initial
    begin : rx_side
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                out_ready <= 1'b0;
            else
            begin
                if (rx_hold_len > 0)
                begin
                    stall_left  = rx_hold_len;
                    rx_hold_len = 0;
                end
                else if (out_valid && out_ready)
                    stall_left = $urandom_range(0, rx_stall_max);
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_ready <= 1'b0;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            if (errors <= MaxReports)
                $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        llf_pkg::out_word_t exp_w;
        if (rst_n && out_valid && out_ready)
        begin
            words_out++;
            if (out_data.line_end === 1'b1)
                lines_closed++;
            if (line_bytes_due.size() == 0)
            begin
                errors++;
                if (errors <= MaxReports)
                    $display("%0t: unexpected word, expected none got %0h",
                             $time, out_data);
            end
            else
            begin
                exp_w = line_bytes_due.pop_front();
                check_field("out_byte", exp_w.out_byte, out_data.out_byte);
                check_field("has_byte", exp_w.has_byte, out_data.has_byte);
                check_field("line_end", exp_w.line_end, out_data.line_end);
                check_field("first_line", exp_w.first_line, out_data.first_line);
                check_field("last_line", exp_w.last_line, out_data.last_line);
            end
        end
    end

    // ------------------------------------------------------------------
    // input side and register port
    // ------------------------------------------------------------------
    task automatic send_word(llf_pkg::in_word_t w);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        track_line(w);
        words_in++;
    endtask

    task automatic send_byte(logic [7:0] b);
        llf_pkg::in_word_t w;
        w.in_byte      = b;
        w.end_of_input = 1'b0;
        send_word(w);
    endtask

    task automatic send_end();
        llf_pkg::in_word_t w;
        // the byte rides along but must be ignored
        w.in_byte      = 8'($urandom);
        w.end_of_input = 1'b1;
        send_word(w);
    endtask

    task automatic play_script();
        foreach (script[i])
        begin
            if (script[i] == EndMark)
                send_end();
            else
                send_byte(script[i][7:0]);
        end
        script.delete();
    endtask

    // stop offering and wait for every due word, then let the block go quiet
    task automatic settle_block();
        in_valid <= 1'b0;
        while (line_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(int idx, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrWidth'(4 * idx);
        pwdata  <= {24'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            llf_pkg::REG_TERMINATOR: rules.terminator_char = value;
            llf_pkg::REG_QUOTE:      rules.quote_char      = value;
            llf_pkg::REG_COMMENT:    rules.comment_char    = value;
            default:                 ;
        endcase
    endtask

    task automatic set_rules(logic [7:0] term, logic [7:0] quote, logic [7:0] cmt);
        settle_block();
        write_reg(llf_pkg::REG_TERMINATOR, term);
        write_reg(llf_pkg::REG_QUOTE, quote);
        write_reg(llf_pkg::REG_COMMENT, cmt);
        settings++;
    endtask

    function automatic logic [7:0] any_byte();
        case ($urandom_range(0, 9))
            0:       return rules.terminator_char;
            1:       return rules.quote_char;
            2:       return rules.comment_char;
            default: return 8'($urandom);
        endcase
    endfunction

    // one physical or logical line with random content
    task automatic send_line();
        int kind;
        int len;
        int ending;
        bit done;
        kind = $urandom_range(0, 19);
        if (kind == 0)
            send_byte(rules.terminator_char);
        else if (kind <= 2)
        begin
            send_byte(rules.comment_char);
            repeat ($urandom_range(0, 8)) send_byte(any_byte());
            if ($urandom_range(0, 4) == 0)
                send_end();
            else
                send_byte(rules.terminator_char);
        end
        else if (kind <= 4)
        begin
            // noise heavy in the special bytes
            repeat ($urandom_range(1, 8))
            begin
                if ($urandom_range(0, 15) == 0)
                    send_end();
                else
                    send_byte(any_byte());
            end
        end
        else
        begin
            done = 1'b0;
            while (!done)
            begin
                len = $urandom_range(1, 10);
                repeat (len) send_byte(any_byte());
                ending = $urandom_range(0, 9);
                if (ending <= 5)
                begin
                    send_byte(rules.terminator_char);
                    done = 1'b1;
                end
                else if (ending <= 7)
                begin
                    send_byte(rules.quote_char);
                    send_byte(rules.terminator_char);
                end
                else
                begin
                    if (ending == 9)
                        send_byte(rules.quote_char);
                    send_end();
                    done = 1'b1;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_default_lines();
        tx_gap_max   = 17;
        rx_stall_max = 17;
        script = {
            TerminatorRst,                                   // blank line
            CommentRst, 8'hFF, TerminatorRst,                // comment line
            QuoteRst, 8'h00, QuoteRst, TerminatorRst,        // leading quote, then a join
            QuoteRst, QuoteRst, CommentRst, TerminatorRst,   // quote pair, comment byte mid-line
            8'h71, QuoteRst, EndMark,                        // end with a quote held
            CommentRst, 8'h63, EndMark,                      // end inside a comment
            EndMark,                                         // end at a line start
            8'hFF, EndMark                                   // end after a plain byte
        };
        play_script();
    endtask

    task automatic test_equal_registers();
        // terminator equals comment: terminator wins
        set_rules(8'h00, 8'hFF, 8'h00);
        script = {8'h00, 8'hFF, 8'hFF, 8'h00, 8'h41, 8'h00};
        play_script();
        // all three equal
        set_rules(8'hFF, 8'hFF, 8'hFF);
        script = {8'hFF, 8'h41, 8'hFF};
        play_script();
        // quote equals comment: comment test comes first
        set_rules(8'h0A, 8'h23, 8'h23);
        script = {8'h23, 8'h0A, 8'h41, 8'h23, 8'h0A, 8'h42, 8'h0A};
        play_script();
        // a write past the last register changes nothing
        settle_block();
        write_reg(UnusedReg, 8'h41);
        script = {8'h41, 8'h0A};
        play_script();
    endtask

    task automatic test_back_pressure();
        settle_block();
        tx_gap_max   = 0;
        rx_stall_max = 0;
        rx_hold_len  = 300;
        repeat (64) send_byte(8'h41 + 8'($urandom_range(0, 25)));
        send_byte(rules.terminator_char);
        // sender waits for the whole backlog to drain
        settle_block();
    endtask

    task automatic test_random_lines();
        int stop;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    set_rules(TerminatorRst, QuoteRst, CommentRst);
                    tx_gap_max   = 0;
                    rx_stall_max = 0;
                end
                1:
                begin
                    set_rules(8'h00, 8'hFF, 8'h80);
                    tx_gap_max   = 17;
                    rx_stall_max = 17;
                end
                2:
                begin
                    set_rules(8'hFF, 8'h00, 8'hFF);
                    tx_gap_max   = 3;
                    rx_stall_max = 17;
                end
                3:
                begin
                    set_rules(8'($urandom), 8'($urandom), 8'($urandom));
                    tx_gap_max   = 17;
                    rx_stall_max = 0;
                end
                4:
                begin
                    // narrow range so the bytes often coincide
                    set_rules(8'h40 + 8'($urandom_range(0, 2)),
                              8'h40 + 8'($urandom_range(0, 2)),
                              8'h40 + 8'($urandom_range(0, 2)));
                    tx_gap_max   = 17;
                    rx_stall_max = 17;
                end
                default:
                begin
                    set_rules(TerminatorRst, QuoteRst, CommentRst);
                    tx_gap_max   = 8;
                    rx_stall_max = 8;
                end
            endcase
            stop = words_in + LineTarget;
            while (words_in < stop)
                send_line();
        end
    endtask

    task automatic finish_run();
        settle_block();
        repeat (20) @(posedge clk);
        $display("run covered %0d input words and %0d output words, %0d lines closed",
                 words_in, words_out, lines_closed);
        $display("%0d register settings, last physical line %0d, %0d cycles",
                 settings, line_last, cycle_count);
        if (errors == 0 && line_bytes_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    endtask

    initial
    begin
        rules.terminator_char = TerminatorRst;
        rules.quote_char      = QuoteRst;
        rules.comment_char    = CommentRst;
        rewind_line();
        line_first = 32'd0;
        line_last  = 32'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_lines();
        test_equal_registers();
        test_back_pressure();
        test_random_lines();
        finish_run();
    end

endmodule

@@ files.f @@
rtl/llf_pkg.sv
rtl/llf_core.sv
rtl/llf_queue.sv
rtl/logical_line_filter.sv
verif/tb_logical_line_filter.sv
